// ----- rtl/core/fuel_dispense_valve_sequencer_defines.svh -----
// Assertion macros for the fuel dispense valve sequencer.
`ifndef FUEL_DISPENSE_VALVE_SEQUENCER_DEFINES_SVH
`define FUEL_DISPENSE_VALVE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define FDVS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define FDVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fdvs_pkg.sv -----
// Types and constants shared by the fuel dispense valve sequencer.
`timescale 1ns / 1ps

package fdvs_pkg;

    localparam int LIMIT_W = 17;
    localparam int PULSE_W = 18;
    localparam int ML_W    = 18;
    localparam int EVENT_W = 2;
    localparam int PROD_W  = LIMIT_W + 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd1000;

    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_NOZZLE  = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_READY   = 2'd1,
        MODE_SHUNT   = 2'd2,
        MODE_RUNNING = 2'd3
    } mode_t;

    typedef struct packed {
        logic [EVENT_W-1:0] handle_event;
        logic [PULSE_W-1:0] pulse_count;
        logic [ML_W-1:0]    milliliters_now;
    } item_t;

    typedef struct packed {
        logic            run_valve;
        logic            shunt_valve;
        logic            reset_counter;
        logic            fueling_done;
        logic            report_valid;
        logic            report_final;
        logic [ML_W-1:0] report_milliliters;
    } result_t;

endpackage

// ----- rtl/core/fdvs_apb_regs.sv -----
// APB configuration register holding the dispensing limit.
`timescale 1ns / 1ps

module fdvs_apb_regs
    import fdvs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [LIMIT_W-1:0] limit_ml
);

    localparam logic REG_LIMIT = 1'b0;

    logic [LIMIT_W-1:0] limit_reg;
    logic               wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT);
    assign limit_ml = limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (wr_en) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_LIMIT: prdata = 32'(limit_reg);
            default:   prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/fdvs_step.sv -----
// Mode state and single-pass next-state logic for one transaction.
`timescale 1ns / 1ps

module fdvs_step
    import fdvs_pkg::*;
#(
    parameter int PULSES_PER_TENTH_LITRE = 112
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  item_t              item,
    input  logic [LIMIT_W-1:0] limit_ml,
    output result_t            res
);

    localparam int STEP_W = $clog2(PULSES_PER_TENTH_LITRE + 1);
    localparam int SUM_W  = ((PULSE_W > STEP_W) ? PULSE_W : STEP_W) + 1;
    localparam logic [SUM_W-1:0] STEP = SUM_W'(PULSES_PER_TENTH_LITRE);

    mode_t              mode_reg, mode_next;
    logic [PULSE_W-1:0] start_reg, start_next;
    logic               run_reg, run_next;
    logic               shunt_reg, shunt_next;

    logic [PROD_W-1:0]  limit_prod;
    logic [SUM_W-1:0]   limit_p;
    logic [SUM_W-1:0]   pulses;
    logic [SUM_W-1:0]   pulses_ahead;
    logic [PULSE_W-1:0] since_start;
    logic               no_limit;
    logic               released;
    logic               rst_cnt, done, rep, fin;

    // limit * 9 / 8
    assign limit_prod   = {1'b0, limit_ml, 3'b000} + PROD_W'(limit_ml);
    assign limit_p      = SUM_W'(limit_prod[PROD_W-1:3]);
    assign no_limit     = (limit_ml == '0);
    assign pulses       = SUM_W'(item.pulse_count);
    assign pulses_ahead = pulses + STEP;
    assign since_start  = item.pulse_count - start_reg;
    assign released     = (item.handle_event == EV_RELEASE);

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        run_next   = run_reg;
        shunt_next = shunt_reg;
        rst_cnt    = 1'b0;
        done       = 1'b0;
        rep        = 1'b0;
        fin        = 1'b0;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (item.handle_event == EV_NOZZLE) begin
                    rst_cnt   = 1'b1;
                    mode_next = MODE_READY;
                end
            end
            MODE_READY: begin
                if (item.handle_event == EV_NOZZLE) begin
                    rst_cnt    = 1'b1;
                    done       = 1'b1;
                    run_next   = 1'b0;
                    shunt_next = 1'b0;
                    mode_next  = MODE_IDLE;
                end else if (item.handle_event == EV_PRESS &&
                             (no_limit || pulses < limit_p)) begin
                    run_next   = 1'b1;
                    shunt_next = 1'b1;
                    start_next = item.pulse_count;
                    mode_next  = MODE_SHUNT;
                end
            end
            MODE_SHUNT: begin
                rep = 1'b1;
                if (released) begin
                    run_next   = 1'b0;
                    shunt_next = 1'b0;
                    mode_next  = MODE_READY;
                end
                if (!no_limit && pulses_ahead >= limit_p) begin
                    if (pulses >= limit_p) begin
                        run_next   = 1'b0;
                        shunt_next = 1'b0;
                        fin        = 1'b1;
                        mode_next  = MODE_READY;
                    end
                end else if (!released && item.pulse_count >= start_reg &&
                             SUM_W'(since_start) >= STEP) begin
                    shunt_next = 1'b0;
                    mode_next  = MODE_RUNNING;
                end
            end
            MODE_RUNNING: begin
                rep = 1'b1;
                if (released) begin
                    run_next  = 1'b0;
                    fin       = 1'b1;
                    mode_next = MODE_READY;
                end else if (!no_limit && pulses_ahead > limit_p) begin
                    shunt_next = 1'b1;
                    start_next = item.pulse_count;
                    mode_next  = MODE_SHUNT;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase

        res.run_valve          = run_next;
        res.shunt_valve        = shunt_next;
        res.reset_counter      = rst_cnt;
        res.fueling_done       = done;
        res.report_valid       = rep;
        res.report_final       = rep && fin;
        res.report_milliliters = rep ? item.milliliters_now : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            run_reg   <= 1'b0;
            shunt_reg <= 1'b0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            run_reg   <= run_next;
            shunt_reg <= shunt_next;
        end
    end

endmodule

// ----- rtl/core/fuel_dispense_valve_sequencer.sv -----
// Fuel dispense valve sequencer: a meter-and-handle transaction in, one valve command out.
// Input channel s_*: handle event plus the flow meter's pulse and millilitre counts.
// Result channel m_*: run/shunt valve levels, counter reset and fueling-done strobes,
// and a volume report while fuel flows. Every input transaction yields one result.
// APB port: register 0 at byte address 0 is the limit in millilitres (0 = unlimited).
// Path: an accepted input lands in the input register, and the result register loads
// from it when the step advances (input register, then result register). Throughput:
// one transaction per cycle while m_ready is high; the single-pass mode update between
// the two registers sets that figure.
// Stalls: when m_ready is low the result register holds, the input register fills,
// and s_ready drops only once both are occupied.
// Reset (aresetn low, synchronous): mode idle, both valves closed, limit 1000 ml,
// both channels empty.
`timescale 1ns / 1ps

`include "fuel_dispense_valve_sequencer_defines.svh"

module fuel_dispense_valve_sequencer
    import fdvs_pkg::*;
#(
    parameter int PULSES_PER_TENTH_LITRE = 112
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [EVENT_W-1:0] s_handle_event,
    input  logic [PULSE_W-1:0] s_pulse_count,
    input  logic [ML_W-1:0]    s_milliliters_now,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_run_valve,
    output logic               m_shunt_valve,
    output logic               m_reset_counter,
    output logic               m_fueling_done,
    output logic               m_report_valid,
    output logic               m_report_final,
    output logic [ML_W-1:0]    m_report_milliliters
);

    logic [LIMIT_W-1:0] limit_ml;
    logic               in_valid_reg;
    item_t              item_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            res;
    logic               advance;

    fdvs_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .limit_ml (limit_ml)
    );

    fdvs_step #(
        .PULSES_PER_TENTH_LITRE (PULSES_PER_TENTH_LITRE)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (item_reg),
        .limit_ml (limit_ml),
        .res      (res)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.handle_event    <= s_handle_event;
            item_reg.pulse_count     <= s_pulse_count;
            item_reg.milliliters_now <= s_milliliters_now;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_run_valve          = out_reg.run_valve;
    assign m_shunt_valve        = out_reg.shunt_valve;
    assign m_reset_counter      = out_reg.reset_counter;
    assign m_fueling_done       = out_reg.fueling_done;
    assign m_report_valid       = out_reg.report_valid;
    assign m_report_final       = out_reg.report_final;
    assign m_report_milliliters = out_reg.report_milliliters;

    // Shunt is only ever open together with the main valve.
    `FDVS_ASSERT_NOW(a_shunt_needs_run, aclk, aresetn, m_valid && m_shunt_valve, m_run_valve, "shunt open with run valve closed")

    // Counter reset strobes only outside flow, reports only during flow.
    `FDVS_ASSERT_NOW(a_reset_vs_report, aclk, aresetn, m_valid && m_reset_counter, !m_report_valid, "counter reset during a flow report")

    // Input side stalls only when both stages hold a transaction.
    `FDVS_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && m_valid && !m_ready, "input stalled without a full pipeline")

    // A held result with a stalled receiver is still there next cycle.
    `FDVS_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_reg), "result changed while stalled")

endmodule
